// File: hw/rtl/stmc_pkg.sv
// ----------------------------------------------------------------------------
// stmc_pkg
// Shared types, operation codes and defaults for the Steiner tree cost block.
// ----------------------------------------------------------------------------
package stmc_pkg;

  // Defaults for the top level parameters
  localparam int DEF_MAX_VERTICES  = 64;
  localparam int DEF_MAX_ARCS      = 512;
  localparam int DEF_MAX_TERMINALS = 8;
  localparam int DEF_COST_BITS     = 48;

  // Fixed field widths
  localparam int VERTEX_W   = 6;
  localparam int WEIGHT_W   = 32;
  localparam int MIN_COST_W = 48;
  localparam int COUNT_W    = 7;
  localparam int CMP_W      = 16;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

  // Operation codes
  localparam logic [1:0] OP_ADD_ARC  = 2'd0;
  localparam logic [1:0] OP_ADD_TERM = 2'd1;
  localparam logic [1:0] OP_SOLVE    = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  typedef struct packed {
    logic [1:0]          operation;
    logic [VERTEX_W-1:0] from_vertex;
    logic [VERTEX_W-1:0] to_vertex;
    logic [WEIGHT_W-1:0] arc_weight;
  } in_word_t;

  typedef struct packed {
    logic [MIN_COST_W-1:0] min_cost;
    logic                  no_solution;
    logic                  load_error;
  } out_word_t;

endpackage

// File: hw/rtl/stmc_ram.sv
// ----------------------------------------------------------------------------
// stmc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module stmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/stmc_alu.sv
// ----------------------------------------------------------------------------
// stmc_alu
// Shared saturating add and less-than compare used by the merge, relax and scan steps.
// ----------------------------------------------------------------------------
module stmc_alu #(
  parameter int COST_BITS = 48
) (
  input  logic [COST_BITS-1:0]                          a_i,
  input  logic [((COST_BITS > 32) ? COST_BITS : 32)-1:0] b_i,
  input  logic [COST_BITS-1:0]                          cmp_i,
  output logic [COST_BITS-1:0]                          sum_o,
  output logic                                          less_o
);

  localparam int BW = (COST_BITS > 32) ? COST_BITS : 32;
  localparam int SW = BW + 1;

  logic [SW-1:0] a_ext;
  logic [SW-1:0] b_ext;
  logic [SW-1:0] sum;
  logic [SW-1:0] inf_ext;
  logic          sat;

  // Add in a wide word, clamp to the all-ones cost
  assign a_ext   = SW'(a_i);
  assign b_ext   = SW'(b_i);
  assign sum     = a_ext + b_ext;
  assign inf_ext = SW'({COST_BITS{1'b1}});
  assign sat     = (a_ext >= inf_ext) || (b_ext >= inf_ext) || (sum >= inf_ext);
  assign sum_o   = sat ? {COST_BITS{1'b1}} : sum[COST_BITS-1:0];
  assign less_o  = sum_o < cmp_i;

endmodule

// File: hw/rtl/steiner_tree_min_cost_top.sv
// ----------------------------------------------------------------------------
// steiner_tree_min_cost_top
// Arc and terminal loader with a Dreyfus-Wagner minimum Steiner cost solver.
// ----------------------------------------------------------------------------
//  channel | dir | word          | handshake
//  in      | in  | in_word_t     | in_valid_i / in_ready_o
//  out     | out | out_word_t    | out_valid_o / out_ready_i
//  cfg     | in  | vertex_count  | cfg_valid_i / cfg_ready_o
//
// Add terminal and clear are done in S_IDLE, add arc also writes in S_ADD; dropped
// adds give a result word. A solve with n vertices runs one shared add/compare unit: per
// subset s, a merge pass over all n vertices and the unordered splits of s, then a scan
// for the least unvisited vertex, whose arc list is walked, until a scan settles nothing;
// a final scan over the full subset gives the result. Reset is asynchronous; no clearing
// pass. in_ready_o is low while busy and while a result word waits on out_ready_i.
module steiner_tree_min_cost_top #(
  parameter int MAX_VERTICES  = stmc_pkg::DEF_MAX_VERTICES,
  parameter int MAX_ARCS      = stmc_pkg::DEF_MAX_ARCS,
  parameter int MAX_TERMINALS = stmc_pkg::DEF_MAX_TERMINALS,
  parameter int COST_BITS     = stmc_pkg::DEF_COST_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  stmc_pkg::in_word_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output stmc_pkg::out_word_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [stmc_pkg::COUNT_W-1:0]    cfg_data_i
);
  import stmc_pkg::*;

  localparam int VB     = $clog2(MAX_VERTICES);
  localparam int AW     = $clog2(MAX_ARCS + 1);
  localparam int AAW    = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
  localparam int KW     = $clog2(MAX_TERMINALS + 1);
  localparam int TB     = MAX_TERMINALS;
  localparam int SUB_AW = TB + VB;
  localparam int BW     = (COST_BITS > 32) ? COST_BITS : 32;
  localparam int ARC_W  = AW + VERTEX_W + WEIGHT_W;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_ADD       = 5'd1;
  localparam logic [4:0] S_OUT       = 5'd2;
  localparam logic [4:0] S_MV_PIX    = 5'd3;
  localparam logic [4:0] S_MV_PAIR   = 5'd4;
  localparam logic [4:0] S_MV_RB     = 5'd5;
  localparam logic [4:0] S_MV_ACC    = 5'd6;
  localparam logic [4:0] S_MV_WR     = 5'd7;
  localparam logic [4:0] S_SC_START  = 5'd8;
  localparam logic [4:0] S_SC        = 5'd9;
  localparam logic [4:0] S_SC_END    = 5'd10;
  localparam logic [4:0] S_HD        = 5'd11;
  localparam logic [4:0] S_AR        = 5'd12;
  localparam logic [4:0] S_AD        = 5'd13;
  localparam logic [4:0] S_RX        = 5'd14;
  localparam logic [4:0] S_NEXT      = 5'd15;
  localparam logic [4:0] S_FIN_START = 5'd16;
  localparam logic [4:0] S_FIN       = 5'd17;
  localparam logic [4:0] S_DONE      = 5'd18;

  localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};
  localparam logic [AW-1:0]        EMPTY_ARC = AW'(MAX_ARCS);

  // Control state
  logic [4:0]          state_q, state_d;
  logic [COUNT_W-1:0]  vcount_q;
  logic [AW-1:0]       arc_total_q, arc_total_d;
  logic [KW-1:0]       term_total_q, term_total_d;
  logic [MAX_VERTICES-1:0] head_vld_q, head_vld_d;
  logic [MAX_VERTICES-1:0] vis_q, vis_d;

  // Datapath registers
  in_word_t            in_q;
  logic [VERTEX_W-1:0] term_q [MAX_TERMINALS];
  logic [TB-1:0]       s_q, s_d, pair_a_q, pair_a_d;
  logic [VB-1:0]       v_q, v_d, best_q, best_d;
  logic [COST_BITS-1:0] acc_q, acc_d, opa_q, opa_d, best_cost_q, best_cost_d;
  logic                found_q, found_d;
  logic [AW-1:0]       arc_ptr_q, arc_ptr_d, guard_q, guard_d;
  logic [AW-1:0]       arc_link_q, arc_link_d;
  logic [VERTEX_W-1:0] arc_dest_q, arc_dest_d;
  logic [WEIGHT_W-1:0] arc_cost_q, arc_cost_d;
  out_word_t           res_q, res_d;

  // RAM ports
  logic              arc_we;
  logic [ARC_W-1:0]  arc_wdata, arc_rdata;
  logic              head_we;
  logic [VB-1:0]     head_raddr;
  logic [AW-1:0]     head_rdata;
  logic              sub_we;
  logic [SUB_AW-1:0] sub_waddr, sub_raddr;
  logic [COST_BITS-1:0] sub_wdata, sub_rdata;

  // Shared unit ports
  logic [COST_BITS-1:0] alu_a, alu_cmp, alu_sum;
  logic [BW-1:0]        alu_b;
  logic                 alu_less;

  // Derived values
  logic [CMP_W-1:0]    n16;
  logic                last_v;
  logic [TB-1:0]       full_set;
  logic [TB-1:0]       pair_b;
  logic                init_zero;
  logic [AW-1:0]       rd_link;
  logic [VERTEX_W-1:0] rd_dest;
  logic                arc_bad;
  logic                accept;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = res_q;
  assign cfg_ready_o = 1'b1;

  // Clamp the vertex count into 1..MAX_VERTICES
  always_comb begin
    n16 = CMP_W'(vcount_q);
    if (n16 == '0) begin
      n16 = CMP_W'(1);
    end else if (n16 > CMP_W'(MAX_VERTICES)) begin
      n16 = CMP_W'(MAX_VERTICES);
    end
  end

  assign last_v   = (CMP_W'(v_q) == (n16 - CMP_W'(1)));
  assign full_set = ~({TB{1'b1}} << term_total_q);
  assign pair_b   = s_q ^ pair_a_q;
  assign rd_link  = arc_rdata[ARC_W-1:VERTEX_W+WEIGHT_W];
  assign rd_dest  = arc_rdata[VERTEX_W+WEIGHT_W-1:WEIGHT_W];
  assign arc_bad  = (arc_total_q >= EMPTY_ARC) ||
                    (CMP_W'(in_data_i.from_vertex) >= CMP_W'(MAX_VERTICES)) ||
                    (CMP_W'(in_data_i.to_vertex) >= CMP_W'(MAX_VERTICES));

  // Singleton subset seed: zero at its terminal's vertex
  always_comb begin
    init_zero = 1'b0;
    for (int i = 0; i < MAX_TERMINALS; i++) begin
      if ((KW'(i) < term_total_q) && (s_q == (TB'(1) << i)) &&
          (CMP_W'(term_q[i]) < n16) && (CMP_W'(term_q[i]) == CMP_W'(v_q))) begin
        init_zero = 1'b1;
      end
    end
  end

  // Route operands into the shared unit
  always_comb begin
    alu_a   = sub_rdata;
    alu_b   = '0;
    alu_cmp = best_cost_q;
    case (state_q)
      S_MV_ACC: begin
        alu_a   = opa_q;
        alu_b   = BW'(sub_rdata);
        alu_cmp = acc_q;
      end
      S_RX: begin
        alu_a   = best_cost_q;
        alu_b   = BW'(arc_cost_q);
        alu_cmp = sub_rdata;
      end
      default: begin
        alu_a   = sub_rdata;
        alu_b   = '0;
        alu_cmp = best_cost_q;
      end
    endcase
  end

  stmc_alu #(
    .COST_BITS(COST_BITS)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .cmp_i (alu_cmp),
    .sum_o (alu_sum),
    .less_o(alu_less)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    arc_total_d  = arc_total_q;
    term_total_d = term_total_q;
    head_vld_d   = head_vld_q;
    vis_d        = vis_q;
    s_d          = s_q;
    pair_a_d     = pair_a_q;
    v_d          = v_q;
    best_d       = best_q;
    acc_d        = acc_q;
    opa_d        = opa_q;
    best_cost_d  = best_cost_q;
    found_d      = found_q;
    arc_ptr_d    = arc_ptr_q;
    guard_d      = guard_q;
    arc_link_d   = arc_link_q;
    arc_dest_d   = arc_dest_q;
    arc_cost_d   = arc_cost_q;
    res_d        = res_q;
    arc_we       = 1'b0;
    arc_wdata    = {(head_vld_q[VB'(in_q.from_vertex)] ? head_rdata : EMPTY_ARC),
                    in_q.to_vertex, in_q.arc_weight};
    head_we      = 1'b0;
    head_raddr   = (state_q == S_IDLE) ? VB'(in_data_i.from_vertex) : best_q;
    sub_we       = 1'b0;
    sub_waddr    = {s_q, v_q};
    sub_wdata    = acc_q;
    sub_raddr    = {s_q, v_q};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          case (in_data_i.operation)
            OP_ADD_ARC: begin
              if (arc_bad) begin
                res_d.load_error = 1'b1;
                state_d = S_OUT;
              end else begin
                state_d = S_ADD;
              end
            end
            OP_ADD_TERM: begin
              if (term_total_q >= KW'(MAX_TERMINALS)) begin
                res_d.load_error = 1'b1;
                state_d = S_OUT;
              end else begin
                term_total_d = term_total_q + KW'(1);
              end
            end
            OP_SOLVE: begin
              if (term_total_q == '0) begin
                state_d = S_OUT;
              end else begin
                s_d     = TB'(1);
                v_d     = '0;
                state_d = S_MV_PIX;
              end
            end
            OP_CLEAR: begin
              head_vld_d   = '0;
              arc_total_d  = '0;
              term_total_d = '0;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      // Link the new arc at the head of its source list
      S_ADD: begin
        arc_we      = 1'b1;
        head_we     = 1'b1;
        head_vld_d[VB'(in_q.from_vertex)] = 1'b1;
        arc_total_d = arc_total_q + AW'(1);
        state_d     = S_IDLE;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      // Merge complementary subsets at vertex v
      S_MV_PIX: begin
        acc_d    = init_zero ? '0 : COST_INF;
        pair_a_d = (s_q - TB'(1)) & s_q;
        state_d  = S_MV_PAIR;
      end
      S_MV_PAIR: begin
        sub_raddr = {pair_a_q, v_q};
        if (pair_a_q == '0) begin
          state_d = S_MV_WR;
        end else if (pair_a_q > pair_b) begin
          pair_a_d = (pair_a_q - TB'(1)) & s_q;
        end else begin
          state_d = S_MV_RB;
        end
      end
      S_MV_RB: begin
        opa_d     = sub_rdata;
        sub_raddr = {pair_b, v_q};
        state_d   = S_MV_ACC;
      end
      S_MV_ACC: begin
        if (alu_less) begin
          acc_d = alu_sum;
        end
        pair_a_d = (pair_a_q - TB'(1)) & s_q;
        state_d  = S_MV_PAIR;
      end
      S_MV_WR: begin
        sub_we = 1'b1;
        if (last_v) begin
          vis_d   = '0;
          state_d = S_SC_START;
        end else begin
          v_d     = v_q + VB'(1);
          state_d = S_MV_PIX;
        end
      end
      // Scan for the least unvisited vertex
      S_SC_START: begin
        v_d         = '0;
        best_cost_d = COST_INF;
        found_d     = 1'b0;
        sub_raddr   = {s_q, {VB{1'b0}}};
        state_d     = S_SC;
      end
      S_SC: begin
        sub_raddr = {s_q, v_q + VB'(1)};
        if (!vis_q[v_q] && alu_less) begin
          best_d      = v_q;
          best_cost_d = sub_rdata;
          found_d     = 1'b1;
        end
        if (last_v) begin
          state_d = S_SC_END;
        end else begin
          v_d = v_q + VB'(1);
        end
      end
      S_SC_END: begin
        if (!found_q) begin
          state_d = S_NEXT;
        end else begin
          vis_d[best_q] = 1'b1;
          state_d = S_HD;
        end
      end
      // Walk the arc list of the settled vertex
      S_HD: begin
        arc_ptr_d = head_vld_q[best_q] ? head_rdata : EMPTY_ARC;
        guard_d   = '0;
        state_d   = S_AR;
      end
      S_AR: begin
        if ((guard_q == EMPTY_ARC) || (arc_ptr_q >= arc_total_q)) begin
          state_d = S_SC_START;
        end else begin
          state_d = S_AD;
        end
      end
      S_AD: begin
        arc_link_d = rd_link;
        arc_dest_d = rd_dest;
        arc_cost_d = arc_rdata[WEIGHT_W-1:0];
        sub_raddr  = {s_q, VB'(rd_dest)};
        if (CMP_W'(rd_dest) < n16) begin
          state_d = S_RX;
        end else begin
          arc_ptr_d = rd_link;
          guard_d   = guard_q + AW'(1);
          state_d   = S_AR;
        end
      end
      S_RX: begin
        sub_waddr = {s_q, VB'(arc_dest_q)};
        sub_wdata = alu_sum;
        sub_we    = alu_less;
        arc_ptr_d = arc_link_q;
        guard_d   = guard_q + AW'(1);
        state_d   = S_AR;
      end
      S_NEXT: begin
        if (s_q == full_set) begin
          state_d = S_FIN_START;
        end else begin
          s_d     = s_q + TB'(1);
          v_d     = '0;
          state_d = S_MV_PIX;
        end
      end
      // Take the least cost over the full subset
      S_FIN_START: begin
        v_d         = '0;
        best_cost_d = COST_INF;
        sub_raddr   = {full_set, {VB{1'b0}}};
        state_d     = S_FIN;
      end
      S_FIN: begin
        sub_raddr = {full_set, v_q + VB'(1)};
        if (alu_less) begin
          best_cost_d = sub_rdata;
        end
        if (last_v) begin
          state_d = S_DONE;
        end else begin
          v_d = v_q + VB'(1);
        end
      end
      S_DONE: begin
        if (best_cost_q == COST_INF) begin
          res_d.no_solution = 1'b1;
        end else begin
          res_d.min_cost = MIN_COST_W'(best_cost_q);
        end
        state_d = S_OUT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      vcount_q     <= VERTEX_COUNT_RST;
      arc_total_q  <= '0;
      term_total_q <= '0;
      head_vld_q   <= '0;
      vis_q        <= '0;
    end else begin
      state_q      <= state_d;
      arc_total_q  <= arc_total_d;
      term_total_q <= term_total_d;
      head_vld_q   <= head_vld_d;
      vis_q        <= vis_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    pair_a_q    <= pair_a_d;
    v_q         <= v_d;
    best_q      <= best_d;
    acc_q       <= acc_d;
    opa_q       <= opa_d;
    best_cost_q <= best_cost_d;
    found_q     <= found_d;
    arc_ptr_q   <= arc_ptr_d;
    guard_q     <= guard_d;
    arc_link_q  <= arc_link_d;
    arc_dest_q  <= arc_dest_d;
    arc_cost_q  <= arc_cost_d;
    res_q       <= res_d;
    if (accept) begin
      in_q <= in_data_i;
    end
    // Store a terminal in the next free slot
    if (accept && (in_data_i.operation == OP_ADD_TERM)) begin
      for (int i = 0; i < MAX_TERMINALS; i++) begin
        if (term_total_q == KW'(i)) begin
          term_q[i] <= in_data_i.from_vertex;
        end
      end
    end
  end

  stmc_ram #(
    .WIDTH(ARC_W),
    .DEPTH(MAX_ARCS)
  ) u_arc_ram (
    .clk_i  (clk_i),
    .we_i   (arc_we),
    .waddr_i(arc_total_q[AAW-1:0]),
    .wdata_i(arc_wdata),
    .raddr_i(arc_ptr_q[AAW-1:0]),
    .rdata_o(arc_rdata)
  );

  stmc_ram #(
    .WIDTH(AW),
    .DEPTH(MAX_VERTICES)
  ) u_head_ram (
    .clk_i  (clk_i),
    .we_i   (head_we),
    .waddr_i(VB'(in_q.from_vertex)),
    .wdata_i(arc_total_q),
    .raddr_i(head_raddr),
    .rdata_o(head_rdata)
  );

  stmc_ram #(
    .WIDTH(COST_BITS),
    .DEPTH(2 ** SUB_AW)
  ) u_subset_ram (
    .clk_i  (clk_i),
    .we_i   (sub_we),
    .waddr_i(sub_waddr),
    .wdata_i(sub_wdata),
    .raddr_i(sub_raddr),
    .rdata_o(sub_rdata)
  );

endmodule

// File: hw/rtl/stmc_checker.sv
// ----------------------------------------------------------------------------
// stmc_checker
// Port level checks for the Steiner tree cost block, bound to the top level.
// ----------------------------------------------------------------------------
module stmc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input stmc_pkg::out_word_t          out_data_o
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Never take input while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready while a result is pending");

  // Return to ready once the result is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> in_ready_o && !out_valid_o)
    else $error("not ready after result taken");

  // Error and no-solution flags are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.no_solution && out_data_o.load_error))
    else $error("both flags set");

  // Flagged results carry no cost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.no_solution || out_data_o.load_error)
      |-> out_data_o.min_cost == '0)
    else $error("flagged result with nonzero cost");

endmodule

bind steiner_tree_min_cost_top stmc_checker u_checker (.*);

// File: tb/sv/steiner_tree_min_cost_top_tb.sv
// ----------------------------------------------------------------------------
// steiner_tree_min_cost_top_tb
// Checks the minimum Steiner tree cost block against a behavioral predictor.
// A short table of directed words comes first, then an arc store fill and overflow,
// then random graphs per phase.
module steiner_tree_min_cost_top_tb;
  import stmc_pkg::*;

  localparam int          HALF      = 6;
  localparam int          ARC_CAP   = DEF_MAX_ARCS;
  localparam int          TERM_CAP  = DEF_MAX_TERMINALS;
  localparam int          VERT_CAP  = DEF_MAX_VERTICES;
  localparam int          WORD_GOAL = 950;
  localparam logic [47:0] COST_INF  = '1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_word_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_word_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [COUNT_W-1:0]  cfg_data = '0;

  // Predictor state
  logic [COUNT_W-1:0]  vcount_reg;
  logic [5:0]          arc_src [ARC_CAP];
  logic [5:0]          arc_dst [ARC_CAP];
  logic [47:0]         arc_wt [ARC_CAP];
  int                  arc_cnt;
  logic [5:0]          term_vtx [TERM_CAP];
  int                  term_cnt;
  logic [47:0]         tree_cost [1 << TERM_CAP][VERT_CAP];

  out_word_t           pending_words [$];
  int                  err_cnt = 0;
  int                  words_sent = 0;
  int                  cyc = 0;
  bit                  hold_req = 1'b0;

  typedef struct {
    bit        is_cfg;
    in_word_t  w;
    bit        typed;
    out_word_t r;
  } dir_row_t;

  dir_row_t dir_rows [$];

  steiner_tree_min_cost_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #HALF clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // Saturating cost add
  function automatic logic [47:0] cost_add(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    if (a == COST_INF || b == COST_INF) return COST_INF;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, COST_INF}) ? COST_INF : s[47:0];
  endfunction

  // Dreyfus-Wagner over the current graph
  function automatic out_word_t steiner_cost();
    out_word_t   r;
    int          n, k, full, best_v;
    logic [47:0] best, c, best_c;
    bit          seen [VERT_CAP];
    r = '0;
    n = (vcount_reg < 1) ? 1 : (vcount_reg > VERT_CAP) ? VERT_CAP : int'(vcount_reg);
    k = term_cnt;
    if (k == 0) return r;
    full = (1 << k) - 1;
    for (int s = 0; s <= full; s++)
      for (int v = 0; v < n; v++) tree_cost[s][v] = COST_INF;
    for (int i = 0; i < k; i++)
      if (term_vtx[i] < n) tree_cost[1 << i][term_vtx[i]] = '0;
    for (int s = 1; s <= full; s++) begin
      // merge complementary halves
      for (int a = (s - 1) & s; a != 0; a = (a - 1) & s) begin
        if (a > (s ^ a)) continue;
        for (int v = 0; v < n; v++) begin
          c = cost_add(tree_cost[a][v], tree_cost[s ^ a][v]);
          if (c < tree_cost[s][v]) tree_cost[s][v] = c;
        end
      end
      // relax over the arcs
      for (int v = 0; v < n; v++) seen[v] = 1'b0;
      for (int step = 0; step < n; step++) begin
        best_v = n;
        best_c = COST_INF;
        for (int v = 0; v < n; v++)
          if (!seen[v] && tree_cost[s][v] < best_c) begin
            best_c = tree_cost[s][v];
            best_v = v;
          end
        if (best_v >= n) break;
        seen[best_v] = 1'b1;
        for (int j = 0; j < arc_cnt; j++)
          if (arc_src[j] == best_v && arc_dst[j] < n) begin
            c = cost_add(best_c, arc_wt[j]);
            if (c < tree_cost[s][arc_dst[j]]) tree_cost[s][arc_dst[j]] = c;
          end
      end
    end
    best = COST_INF;
    for (int v = 0; v < n; v++)
      if (tree_cost[full][v] < best) best = tree_cost[full][v];
    if (best == COST_INF) r.no_solution = 1'b1;
    else r.min_cost = best;
    return r;
  endfunction

  // Advance the predictor by one accepted word
  function automatic bit apply_word(in_word_t w, output out_word_t r);
    r = '0;
    case (w.operation)
      OP_ADD_ARC: begin
        if (arc_cnt >= ARC_CAP) begin
          r.load_error = 1'b1;
          return 1'b1;
        end
        arc_src[arc_cnt] = w.from_vertex;
        arc_dst[arc_cnt] = w.to_vertex;
        arc_wt[arc_cnt] = {16'd0, w.arc_weight};
        arc_cnt++;
        return 1'b0;
      end
      OP_ADD_TERM: begin
        if (term_cnt >= TERM_CAP) begin
          r.load_error = 1'b1;
          return 1'b1;
        end
        term_vtx[term_cnt] = w.from_vertex;
        term_cnt++;
        return 1'b0;
      end
      OP_SOLVE: begin
        r = steiner_cost();
        return 1'b1;
      end
      default: begin
        arc_cnt = 0;
        term_cnt = 0;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic bit quiet_window();
    return cyc >= 20000 && cyc < 60000;
  endfunction

  // Offer one word, idling at random, and hold it until accepted
  task automatic push_word(in_word_t w, bit typed = 1'b0, out_word_t tr = '0);
    out_word_t r;
    bit        got;
    @(negedge clk);
    while (!quiet_window() && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    got = apply_word(w, r);
    if (got) pending_words.push_back(typed ? tr : r);
  endtask

  // Drop valid and wait for every expected word
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [COUNT_W-1:0] v);
    drain();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    vcount_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t mk(logic [1:0] op, int f = 0, int t = 0,
                                  logic [31:0] wt = '0);
    in_word_t w;
    w.operation   = op;
    w.from_vertex = f[5:0];
    w.to_vertex   = t[5:0];
    w.arc_weight  = wt;
    return w;
  endfunction

  function automatic void row(bit is_cfg, in_word_t w, bit typed = 1'b0,
                              logic [47:0] mc = '0, bit ns = 1'b0, bit le = 1'b0);
    dir_row_t d;
    d.is_cfg = is_cfg;
    d.w      = w;
    d.typed  = typed;
    d.r      = '{min_cost: mc, no_solution: ns, load_error: le};
    dir_rows.push_back(d);
  endfunction

  function automatic logic [31:0] rand_weight();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(20);
    if (r < 90) return $urandom;
    return (r < 95) ? 32'd0 : 32'hFFFF_FFFF;
  endfunction

  function automatic int rand_vertex(int n);
    return ($urandom_range(99) < 85) ? $urandom_range(n - 1) : $urandom_range(63);
  endfunction

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        out_ready <= 1'b0;
        hold_cnt--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_window() || ($urandom_range(99) >= 14);
      end
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_data);
        err_cnt++;
      end else begin
        e = pending_words.pop_front();
        if (out_data.min_cost !== e.min_cost) begin
          $display("%0t: min_cost expected %h actual %h", $time, e.min_cost,
                   out_data.min_cost);
          err_cnt++;
        end
        if (out_data.no_solution !== e.no_solution) begin
          $display("%0t: no_solution expected %b actual %b", $time, e.no_solution,
                   out_data.no_solution);
          err_cnt++;
        end
        if (out_data.load_error !== e.load_error) begin
          $display("%0t: load_error expected %b actual %b", $time, e.load_error,
                   out_data.load_error);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #(HALF * 2 * 8000000);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int n, k, m, f, t, r;
    vcount_reg = VERTEX_COUNT_RST;
    arc_cnt    = 0;
    term_cnt   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table: empty list, single terminal, extremes, full store
    row(0, mk(OP_SOLVE), 1, 48'd0);
    row(0, mk(OP_ADD_TERM, 5));
    row(0, mk(OP_SOLVE), 1, 48'd0);
    row(0, mk(OP_ADD_ARC, 5, 9, 32'hFFFF_FFFF));
    row(0, mk(OP_ADD_ARC, 9, 5, 32'd0));
    row(0, mk(OP_ADD_TERM, 9));
    row(0, mk(OP_SOLVE));
    row(0, mk(OP_ADD_ARC, 63, 0, 32'h8000_0000));
    row(0, mk(OP_ADD_ARC, 0, 63, 32'd1));
    row(0, mk(OP_ADD_TERM, 63));
    row(0, mk(OP_SOLVE));
    row(1, mk(OP_ADD_ARC, 2));
    row(0, mk(OP_SOLVE), 1, 48'd0, 1'b1);
    row(0, mk(OP_ADD_TERM, 63));
    row(0, mk(OP_ADD_TERM, 0));
    row(0, mk(OP_ADD_TERM, 1));
    row(0, mk(OP_ADD_TERM, 1));
    row(0, mk(OP_ADD_TERM, 0));
    row(0, mk(OP_ADD_TERM, 1), 1, 48'd0, 1'b0, 1'b1);
    row(0, mk(OP_SOLVE), 1, 48'd0, 1'b1);
    row(0, mk(OP_CLEAR));
    row(1, mk(OP_ADD_ARC, 0));
    row(0, mk(OP_ADD_TERM, 0));
    row(0, mk(OP_SOLVE), 1, 48'd0);
    row(1, mk(OP_ADD_ARC, 127));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) cfg_write(dir_rows[i].w.from_vertex);
      else push_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);
    end
    // vertex count 127 stands for the full graph
    cfg_data <= '0;
    drain();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= 7'd127;
    do @(posedge clk); while (!cfg_ready);
    vcount_reg = 7'd127;
    @(negedge clk);
    cfg_valid <= 1'b0;
    push_word(mk(OP_ADD_ARC, 0, 1, 32'd7));
    push_word(mk(OP_ADD_TERM, 1));
    push_word(mk(OP_SOLVE));

    // Fill the arc store, then overflow it while the receiver holds off
    cfg_write(7'd4);
    push_word(mk(OP_CLEAR));
    for (int i = 0; i < ARC_CAP; i++)
      push_word(mk(OP_ADD_ARC, $urandom_range(3), $urandom_range(3), rand_weight()));
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++)
      push_word(mk(OP_ADD_ARC, $urandom_range(63), $urandom_range(63), $urandom));
    push_word(mk(OP_ADD_TERM, 0));
    push_word(mk(OP_ADD_TERM, 3));
    push_word(mk(OP_SOLVE));

    // Random graphs, one vertex count per phase
    while (words_sent < WORD_GOAL) begin
      r = $urandom_range(99);
      if (r < 12) begin
        n = $urandom_range(1, 4);
        k = $urandom_range(0, 9);
      end else if (r < 22) begin
        n = (r < 15) ? 0 : (r < 18) ? 127 : 64;
        k = $urandom_range(0, 3);
      end else begin
        n = $urandom_range(2, 16);
        k = $urandom_range(0, 4);
      end
      cfg_write(n[COUNT_W-1:0]);
      if (n < 1) n = 1;
      if (n > VERT_CAP) n = VERT_CAP;
      push_word(mk(OP_CLEAR, $urandom, $urandom, $urandom));
      m = $urandom_range(0, (3 * n > 40) ? 40 : 3 * n);
      for (int i = 0; i < m; i++) begin
        f = rand_vertex(n);
        t = rand_vertex(n);
        push_word(mk(OP_ADD_ARC, f, t, rand_weight()));
        if ($urandom_range(99) < 60) push_word(mk(OP_ADD_ARC, t, f, rand_weight()));
      end
      for (int i = 0; i < k; i++)
        push_word(mk(OP_ADD_TERM, rand_vertex(n), $urandom, $urandom));
      push_word(mk(OP_SOLVE, $urandom, $urandom, $urandom));
      // at random, let the pipe empty before the next phase starts
      if ($urandom_range(99) < 10) drain();
    end

    drain();
    repeat (50) @(posedge clk);
    if (err_cnt == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: steiner_tree_min_cost_top.f
hw/rtl/stmc_pkg.sv
hw/rtl/stmc_ram.sv
hw/rtl/stmc_alu.sv
hw/rtl/steiner_tree_min_cost_top.sv
hw/rtl/stmc_checker.sv
tb/sv/steiner_tree_min_cost_top_tb.sv
